// File: hdl/three_axis_mean_stddev_baseline_top_assert.svh
// Assertion macros for the baseline block.
`ifndef THREE_AXIS_MEAN_STDDEV_BASELINE_TOP_ASSERT_SVH
`define THREE_AXIS_MEAN_STDDEV_BASELINE_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define TAMSB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next cycle.
`define TAMSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tamsb_pkg.sv
package tamsb_pkg;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS + 1;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS + COUNT_BITS;
    // n*Q - S*S, scaled by 4^FRAC_BITS
    localparam int VAR_BITS    = SQ_BITS + COUNT_BITS + 2 * FRAC_BITS;
    localparam int DEN_BITS    = 2 * COUNT_BITS;
    localparam int MQ_BITS     = SUM_BITS + FRAC_BITS;
    localparam int ROOT_BITS   = (VAR_BITS + 1) / 2;
    localparam int IDX_BITS    = $clog2(VAR_BITS + 1);
    localparam logic [15:0] TARGET_RESET = 16'd4000;
    localparam logic [1:0]  REQ_SAMPLE   = 2'd0;
    localparam logic [1:0]  REQ_FAIL     = 2'd1;
    localparam logic [1:0]  REQ_START    = 2'd2;
    localparam logic [1:0]  REQ_RESERVED = 2'd3;
    localparam logic [0:0]  ADDR_TARGET  = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_NQ,
        ST_SS,
        ST_MEAN,
        ST_VDIV,
        ST_ROOT,
        ST_NEXT,
        ST_OUT
    } t_state;
endpackage

// File: hdl/three_axis_mean_stddev_baseline_top.sv
// Three-axis mean and sample standard deviation.
// Input stream: s_axis beats carry a request kind in tuser (0 sample, 1 read
// failure, 2 start) and three signed 16-bit samples in tdata (x lowest).
// A sample adds to exact per-axis sums and sums of squares; when the count
// reaches sample_target (APB register at address 0) or 65535, one result
// beat leaves on m_axis: status in tuser, means and spreads in tdata.
// A read failure gives one beat with status 1 and zero statistics. After a
// result, samples and failures are dropped until a start beat clears state.
// One shared bit-serial shift-add unit squares each axis, one multiplier bit
// a cycle, then accumulates the square and the sum; the next beat is taken
// only after all three axes are done. Per axis the result takes a 17-step n*Q
// multiply, a 33-step S*S multiply, an 80-step mean division, an 81-step
// variance division, a 41-step root and a store step; after the third axis
// the result beat is loaded into the output register.
// Start and dropped beats are taken in IDLE; a failure beat is valid in the
// cycle after it is taken. Reset clears sums, count and state and loads the
// target with 4000. A stalled result beat is held in the output register;
// no input is taken until it leaves.
module three_axis_mean_stddev_baseline_top
    import tamsb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // accel_x, accel_y, accel_z
    input  logic [1:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,  // mean_x/y/z, spread_x/y/z, samples_used
    output logic         m_axis_tuser,  // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    t_state r_state, n_state;
    logic [15:0] r_target;
    logic signed [SUM_BITS-1:0] r_sum [3];
    logic [SQ_BITS-1:0] r_sq [3];
    logic [COUNT_BITS-1:0] r_count;
    logic r_done;
    logic [47:0] r_samp;
    logic [1:0] r_axis;
    logic [IDX_BITS-1:0] r_step;
    // shared serial datapath
    logic [VAR_BITS-1:0] r_acc, r_opa, r_var;
    logic [VAR_BITS:0] r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [DEN_BITS-1:0] r_den;
    logic [23:0] r_mean [3], r_spr [3];
    logic r_neg;
    logic [159:0] r_odata;
    logic r_ouser, r_ovalid;

    logic signed [SAMPLE_BITS-1:0] w_s;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SUM_BITS-1:0] w_smag;
    logic w_accept, w_wr;
    logic [VAR_BITS:0] w_trial;
    logic [ROOT_BITS+1:0] w_rtrial;
    logic [VAR_BITS+1:0] w_rrem;

    assign pready = 1'b1;
    assign w_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == ADDR_TARGET) ? {16'd0, r_target} : 32'd0;
    assign s_axis_tready = (r_state == ST_IDLE) & ~r_ovalid;
    assign w_accept = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_ouser;

    assign w_s = r_samp[r_axis*16 +: 16];
    assign w_mag = w_s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-w_s) : w_s;
    assign w_smag = r_sum[r_axis][SUM_BITS-1] ? SUM_BITS'(-r_sum[r_axis])
                                              : SUM_BITS'(r_sum[r_axis]);
    // restoring division step
    assign w_trial = {r_rem[VAR_BITS-1:0], r_opa[VAR_BITS-1]};
    // root digit step: remainder extended by two bits against 4r+1
    assign w_rrem = {r_rem, r_var[VAR_BITS-1 -: 1]};
    assign w_rtrial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_target <= TARGET_RESET;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
            r_axis   <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
                r_sq[a]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_wr && paddr[2] == ADDR_TARGET) r_target <= pwdata[15:0];
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: if (w_accept) begin
                    r_samp <= s_axis_tdata;
                    r_axis <= '0;
                    r_step <= '0;
                    r_acc  <= '0;
                    if (s_axis_tuser == REQ_START) begin
                        r_count <= '0;
                        r_done  <= 1'b0;
                        for (int a = 0; a < 3; a++) begin
                            r_sum[a] <= '0;
                            r_sq[a]  <= '0;
                        end
                    end else if (s_axis_tuser == REQ_FAIL && !r_done) begin
                        r_done   <= 1'b1;
                        r_ouser  <= 1'b1;
                        r_odata  <= {r_count, 144'd0};
                        r_ovalid <= 1'b1;
                    end
                end
                ST_SQUARE: begin
                    // one multiplier bit a cycle
                    if (w_mag[r_step[3:0]])
                        r_acc <= r_acc + (VAR_BITS'(w_mag) << r_step[3:0]);
                    r_step <= r_step + 1'b1;
                end
                ST_ACCUM: begin
                    r_sq[r_axis]  <= r_sq[r_axis] + SQ_BITS'(r_acc);
                    r_sum[r_axis] <= r_sum[r_axis] + SUM_BITS'(w_s);
                    r_acc  <= '0;
                    r_step <= '0;
                    if (r_axis == 2'd2) begin
                        r_axis  <= '0;
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                ST_NQ: begin
                    // n*Q: shift-add over count bits
                    if (r_step == '0) begin
                        r_acc <= '0;
                        r_neg <= r_sum[r_axis][SUM_BITS-1];
                        r_den <= DEN_BITS'(r_count) * DEN_BITS'(r_count - 1'b1);
                    end else if (r_count[r_step[3:0] - 1'b1]) begin
                        r_acc <= r_acc + (VAR_BITS'(r_sq[r_axis]) << (r_step[3:0] - 1'b1));
                    end
                    r_step <= (r_step == IDX_BITS'(COUNT_BITS)) ? '0 : r_step + 1'b1;
                end
                ST_SS: begin
                    // subtract |S|*|S| a bit at a time
                    if (w_smag[r_step[5:0]])
                        r_acc <= r_acc - (VAR_BITS'(w_smag) << r_step[5:0]);
                    if (r_step == IDX_BITS'(SUM_BITS - 1)) begin
                        r_step <= '0;
                        r_opa  <= VAR_BITS'(w_smag) << FRAC_BITS;
                        r_rem  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_MEAN: begin
                    if (w_trial >= (VAR_BITS+1)'(r_count)) begin
                        r_rem <= w_trial - (VAR_BITS+1)'(r_count);
                        r_opa <= {r_opa[VAR_BITS-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_opa <= {r_opa[VAR_BITS-2:0], 1'b0};
                    end
                    if (r_step == IDX_BITS'(VAR_BITS - 1)) begin
                        r_step <= '0;
                        r_var  <= r_acc << (2 * FRAC_BITS);
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_VDIV: begin
                    if (r_step == '0) begin
                        // latch the mean, load dividend
                        if (r_neg)
                            r_mean[r_axis] <= (r_opa > VAR_BITS'(24'h800000)) ? 24'h800000
                                              : 24'(-r_opa);
                        else
                            r_mean[r_axis] <= (r_opa > VAR_BITS'(24'h7FFFFF)) ? 24'h7FFFFF
                                              : r_opa[23:0];
                        r_opa  <= r_var;
                        r_rem  <= '0;
                        r_step <= IDX_BITS'(1);
                    end else begin
                        if (w_trial >= (VAR_BITS+1)'(r_den)) begin
                            r_rem <= w_trial - (VAR_BITS+1)'(r_den);
                            r_opa <= {r_opa[VAR_BITS-2:0], 1'b1};
                        end else begin
                            r_rem <= w_trial;
                            r_opa <= {r_opa[VAR_BITS-2:0], 1'b0};
                        end
                        if (r_step == IDX_BITS'(VAR_BITS)) begin
                            r_step <= '0;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                ST_ROOT: begin
                    if (r_step == '0) begin
                        r_var  <= r_opa;
                        r_rem  <= '0;
                        r_root <= '0;
                        r_step <= IDX_BITS'(1);
                    end else begin
                        // two radicand bits in per digit
                        if ({w_rrem[VAR_BITS-1:0], r_var[VAR_BITS-2]} >=
                            (VAR_BITS+1)'(w_rtrial)) begin
                            r_rem  <= {w_rrem[VAR_BITS-1:0], r_var[VAR_BITS-2]}
                                      - (VAR_BITS+1)'(w_rtrial);
                            r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
                        end else begin
                            r_rem  <= {w_rrem[VAR_BITS-1:0], r_var[VAR_BITS-2]};
                            r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
                        end
                        r_var <= r_var << 2;
                        r_step <= (r_step == IDX_BITS'(ROOT_BITS)) ? '0 : r_step + 1'b1;
                    end
                end
                ST_NEXT: begin
                    if (r_count <= COUNT_BITS'(1))
                        r_spr[r_axis] <= '0;
                    else
                        r_spr[r_axis] <= (|r_root[ROOT_BITS-1:24]) ? 24'hFFFFFF
                                         : r_root[23:0];
                    r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 1'b1;
                    r_step <= '0;
                end
                ST_OUT: begin
                    r_done   <= 1'b1;
                    r_ouser  <= 1'b0;
                    r_odata  <= {r_count, r_spr[2], r_spr[1], r_spr[0],
                                 r_mean[2], r_mean[1], r_mean[0]};
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:
                if (w_accept && s_axis_tuser == REQ_SAMPLE && !r_done) n_state = ST_SQUARE;
            ST_SQUARE:
                if (r_step == IDX_BITS'(SAMPLE_BITS - 1)) n_state = ST_ACCUM;
            ST_ACCUM:
                if (r_axis != 2'd2) n_state = ST_SQUARE;
                else if (r_count + 1'b1 >= r_target || r_count + 1'b1 == '1)
                    n_state = ST_NQ;
                else n_state = ST_IDLE;
            ST_NQ:   if (r_step == IDX_BITS'(COUNT_BITS)) n_state = ST_SS;
            ST_SS:   if (r_step == IDX_BITS'(SUM_BITS - 1)) n_state = ST_MEAN;
            ST_MEAN: if (r_step == IDX_BITS'(VAR_BITS - 1)) n_state = ST_VDIV;
            ST_VDIV: if (r_step == IDX_BITS'(VAR_BITS)) n_state = ST_ROOT;
            ST_ROOT: if (r_step == IDX_BITS'(ROOT_BITS)) n_state = ST_NEXT;
            ST_NEXT: n_state = (r_axis == 2'd2) ? ST_OUT : ST_NQ;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    `include "three_axis_mean_stddev_baseline_top_assert.svh"

    `TAMSB_ASSERT(a_no_take_busy, i_clk, i_rst_n, !(w_accept && r_ovalid), "input taken while result pending")
    `TAMSB_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, r_state == ST_OUT, r_done && r_ovalid, "result not issued")
    `TAMSB_ASSERT(a_axis_range, i_clk, i_rst_n, r_axis != 2'd3, "axis index out of range")
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb
    import tamsb_pkg::*;
();

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;   // accel_x, accel_y, accel_z
    logic [1:0]   s_axis_tuser;   // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;   // mean_x/y/z, spread_x/y/z, samples_used
    logic         m_axis_tuser;   // status
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    typedef struct packed {
        logic        status;
        logic [23:0] mean_x, mean_y, mean_z;
        logic [23:0] spread_x, spread_y, spread_z;
        logic [15:0] samples_used;
    } t_baseline;

    three_axis_mean_stddev_baseline_top dut (.*);

    // predictor state
    logic [15:0]         target_reg;
    logic signed [63:0]  axis_sum [3];
    logic [127:0]        axis_sq [3];
    logic [15:0]         count_acc;
    logic                done_flag;

    t_baseline baseline_q[$];
    int        fail_count;
    bit        tx_idle_on;
    bit        rx_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic logic [63:0] root_floor(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= v) r = c;
        end
        return r;
    endfunction

    function automatic void clear_baseline();
        for (int a = 0; a < 3; a++) begin
            axis_sum[a] = '0;
            axis_sq[a]  = '0;
        end
        count_acc = '0;
        done_flag = 1'b0;
    endfunction

    function automatic void predict_beat(input logic [1:0] kind, input logic [47:0] data);
        t_baseline         res;
        logic signed [63:0] s;
        logic [63:0]       mag, q, n, spread;
        logic [127:0]      d;
        logic [23:0]       means [3];
        logic [23:0]       spreads [3];
        if (kind == REQ_START) begin
            clear_baseline();
            return;
        end
        if (kind == REQ_RESERVED || done_flag) return;
        if (kind == REQ_FAIL) begin
            done_flag = 1'b1;
            res = '0;
            res.status = 1'b1;
            res.samples_used = count_acc;
            baseline_q.push_back(res);
            return;
        end
        for (int a = 0; a < 3; a++) begin
            s = 64'(signed'(data[16*a +: 16]));
            mag = (s < 0) ? -s : s;
            axis_sum[a] += s;
            axis_sq[a]  += 128'(mag) * 128'(mag);
        end
        count_acc++;
        if (count_acc < target_reg && count_acc != 16'hFFFF) return;
        done_flag = 1'b1;
        n = 64'(count_acc);
        for (int a = 0; a < 3; a++) begin
            s = axis_sum[a];
            mag = (s < 0) ? -s : s;
            q = (mag << FRAC_BITS) / n;
            if (s < 0) begin
                if (q > 64'h800000) q = 64'h800000;
                means[a] = 24'(64'h1000000 - q);
            end else begin
                if (q > 64'h7FFFFF) q = 64'h7FFFFF;
                means[a] = q[23:0];
            end
            spread = '0;
            if (n > 1) begin
                d = axis_sq[a] * 128'(n) - 128'(mag) * 128'(mag);
                d = d << (2 * FRAC_BITS);
                spread = root_floor(d / 128'(n * (n - 1)));
                if (spread > 64'hFFFFFF) spread = 64'hFFFFFF;
            end
            spreads[a] = spread[23:0];
        end
        res.status = 1'b0;
        res.mean_x = means[0];
        res.mean_y = means[1];
        res.mean_z = means[2];
        res.spread_x = spreads[0];
        res.spread_y = spreads[1];
        res.spread_z = spreads[2];
        res.samples_used = count_acc;
        baseline_q.push_back(res);
    endfunction

    // result checker and sink stalls
    initial begin
        t_baseline want;
        t_baseline got;
        int        stall;
        m_axis_tready <= 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.status       = m_axis_tuser;
                got.mean_x       = m_axis_tdata[23:0];
                got.mean_y       = m_axis_tdata[47:24];
                got.mean_z       = m_axis_tdata[71:48];
                got.spread_x     = m_axis_tdata[95:72];
                got.spread_y     = m_axis_tdata[119:96];
                got.spread_z     = m_axis_tdata[143:120];
                got.samples_used = m_axis_tdata[159:144];
                if (baseline_q.size() == 0) begin
                    report("unexpected beat", 64'(got.samples_used), 64'd0);
                end else begin
                    want = baseline_q.pop_front();
                    if (got.status !== want.status)
                        report("status", 64'(got.status), 64'(want.status));
                    if (got.mean_x !== want.mean_x)
                        report("mean_x", 64'(got.mean_x), 64'(want.mean_x));
                    if (got.mean_y !== want.mean_y)
                        report("mean_y", 64'(got.mean_y), 64'(want.mean_y));
                    if (got.mean_z !== want.mean_z)
                        report("mean_z", 64'(got.mean_z), 64'(want.mean_z));
                    if (got.spread_x !== want.spread_x)
                        report("spread_x", 64'(got.spread_x), 64'(want.spread_x));
                    if (got.spread_y !== want.spread_y)
                        report("spread_y", 64'(got.spread_y), 64'(want.spread_y));
                    if (got.spread_z !== want.spread_z)
                        report("spread_z", 64'(got.spread_z), 64'(want.spread_z));
                    if (got.samples_used !== want.samples_used)
                        report("samples_used", 64'(got.samples_used),
                               64'(want.samples_used));
                end
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // valid stays high after the handshake; the caller's next step drives it
    task automatic send_beat(input logic [1:0] kind, input logic [47:0] data);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_beat(kind, data);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (baseline_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ADDR_TARGET, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        target_reg = value;
    endtask

    function automatic logic [47:0] rand_sample();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    task automatic test_directed();
        write_target(16'd3);
        send_beat(REQ_SAMPLE, {16'h7FFF, 16'h8000, 16'h0000});
        send_beat(REQ_SAMPLE, {16'h8000, 16'h7FFF, 16'hFFFF});
        send_beat(REQ_SAMPLE, {16'h8000, 16'h8000, 16'h0001});
        send_beat(REQ_SAMPLE, rand_sample());      // dropped after finishing
        send_beat(REQ_FAIL, 48'd0);                // dropped after finishing
        send_beat(REQ_START, 48'd0);
        send_beat(REQ_SAMPLE, {3{16'h7FFF}});
        send_beat(REQ_FAIL, 48'd0);
        send_beat(REQ_START, 48'd0);
        send_beat(REQ_FAIL, 48'd0);                // failure with no samples
        send_beat(REQ_RESERVED, rand_sample());    // undefined kind
        send_beat(REQ_START, 48'd0);
        wait_drained();
        write_target(16'd1);
        send_beat(REQ_SAMPLE, {3{16'h8000}});
        send_beat(REQ_START, 48'd0);
        send_beat(REQ_RESERVED, 48'hFFFF_FFFF_FFFF);
        send_beat(REQ_SAMPLE, 48'hFFFF_FFFF_FFFF);
        wait_drained();
        // zero target behaves as one
        write_target(16'd0);
        send_beat(REQ_START, 48'd0);
        send_beat(REQ_SAMPLE, 48'h1234_5678_9ABC);
        wait_drained();
        // lower the target below the running count
        write_target(16'd10);
        send_beat(REQ_START, 48'd0);
        repeat (4) send_beat(REQ_SAMPLE, rand_sample());
        wait_drained();
        write_target(16'd2);
        send_beat(REQ_SAMPLE, rand_sample());
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        int r;
        for (int k = 0; k < 1300; k++) begin
            if (k % 100 == 0) begin
                wait_drained();
                n = $urandom_range(0, 4);
                write_target(n == 0 ? 16'd1 : 16'($urandom_range(2, 12)));
            end
            r = $urandom_range(0, 99);
            if (r < 80) send_beat(REQ_SAMPLE, rand_sample());
            else if (r < 85) send_beat(REQ_FAIL, rand_sample());
            else if (r < 97) send_beat(REQ_START, rand_sample());
            else send_beat(REQ_RESERVED, rand_sample());
            if (k == 650) wait_drained();
        end
        wait_drained();
    endtask

    // closing run with no idling on either side, three full baselines
    task automatic test_long_run();
        write_target(16'd40);
        send_beat(REQ_START, 48'd0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int k = 0; k < 120; k++) begin
            if (k % 40 == 0 && k != 0) send_beat(REQ_START, 48'd0);
            send_beat(REQ_SAMPLE, {3{16'h7FFF}} ^ 48'(k & 1));
        end
        wait_drained();
        write_target(TARGET_RESET);
    endtask

    initial begin
        fail_count    = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        target_reg = TARGET_RESET;
        clear_baseline();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_long_run();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hdl
hdl/tamsb_pkg.sv
hdl/three_axis_mean_stddev_baseline_top.sv
sim/tb.sv
